FILE: src/fss_pkg.sv
// Shared types, constants and helper functions for the Fermat spiral surface evaluator.
`default_nettype none
package fss_pkg;

	// Field fraction bits and internal angle format.
	localparam int FracBits = 16;
	localparam int AngBits  = 30;

	// Angle constants at 30 fractional bits.
	localparam logic [34:0] TwoPiQ   = 35'd6746518852;
	localparam logic [34:0] FourPiQ  = 35'd13493037704;
	localparam logic signed [35:0] PiQ     = 36'sd3373259426;
	localparam logic signed [35:0] HalfPiQ = 36'sd1686629713;
	localparam logic signed [35:0] TwoPiS  = 36'sd6746518852;
	localparam logic signed [34:0] GainQ   = 35'sd652032875;

	// Number of square root steps; also the length of the iteration pipeline.
	localparam int SqrtSteps = 32;

	// Data carried through the iteration pipeline.
	typedef struct packed {
		logic [19:0]        u;
		logic [16:0]        v;
		logic               neg;
		logic signed [34:0] x;
		logic signed [34:0] y;
		logic signed [35:0] r;
		logic [63:0]        m;
		logic [63:0]        res;
	} fss_data_t;

	// One complete result.
	typedef struct packed {
		logic [23:0] duu_z;
		logic [23:0] duu_x;
		logic [20:0] normal_z;
		logic [20:0] normal_x;
		logic [23:0] dv_y;
		logic [20:0] du_z;
		logic [20:0] du_x;
		logic [19:0] pos_z;
		logic [23:0] pos_y;
		logic [19:0] pos_x;
	} fss_result_t;

	// Arctangent of 2^-i at 30 fractional bits.
	function automatic logic signed [35:0] atan_entry(input int i);
		logic signed [35:0] val;
		case (i)
			0:  val = 36'sd843314857;
			1:  val = 36'sd497837829;
			2:  val = 36'sd263043837;
			3:  val = 36'sd133525159;
			4:  val = 36'sd67021687;
			5:  val = 36'sd33543516;
			6:  val = 36'sd16775851;
			7:  val = 36'sd8388437;
			8:  val = 36'sd4194283;
			9:  val = 36'sd2097149;
			10: val = 36'sd1048576;
			default: val = (i <= AngBits) ? (36'sd1 <<< (AngBits - i)) : 36'sd0;
		endcase
		return val;
	endfunction

	// Round half up, then arithmetic shift right.
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
		logic signed [63:0] t;
		t = v + (64'sd1 <<< (s - 1));
		return t >>> s;
	endfunction

	// Clamp to [lo, hi].
	function automatic logic signed [63:0] sat(input logic signed [63:0] v,
		input logic signed [63:0] lo, input logic signed [63:0] hi);
		logic signed [63:0] t;
		t = (v < lo) ? lo : ((v > hi) ? hi : v);
		return t;
	endfunction

endpackage
`default_nettype wire

FILE: src/fss_step.sv
// One pipeline stage holding a CORDIC rotation step and a square root step.
`default_nettype none
module fss_step #(
	parameter int IDX    = 0,
	parameter bit ACTIVE = 1'b1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  wire                 valid_in,
	input  fss_pkg::fss_data_t  data_in,
	output logic                valid_s1,
	output fss_pkg::fss_data_t  data_s1
);
	import fss_pkg::*;

	localparam logic [63:0] SqBit = 64'd1 << (62 - 2 * IDX);

	fss_data_t nxt;
	logic [63:0] trial;

	// Rotation toward zero residual angle, and one result bit of the root.
	always_comb begin
		nxt = data_in;
		if (ACTIVE) begin
			if (!data_in.r[35]) begin
				nxt.x = data_in.x - (data_in.y >>> IDX);
				nxt.y = data_in.y + (data_in.x >>> IDX);
				nxt.r = data_in.r - atan_entry(IDX);
			end else begin
				nxt.x = data_in.x + (data_in.y >>> IDX);
				nxt.y = data_in.y - (data_in.x >>> IDX);
				nxt.r = data_in.r + atan_entry(IDX);
			end
		end
		trial = data_in.res + SqBit;
		if (data_in.m >= trial) begin
			nxt.m   = data_in.m - trial;
			nxt.res = (data_in.res >> 1) + SqBit;
		end else begin
			nxt.res = data_in.res >> 1;
		end
	end

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: src/fss_post.sv
// Output arithmetic: products, rounding and saturation of all result fields.
`default_nettype none
module fss_post (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  adv,
	input  wire                  valid_in,
	input  fss_pkg::fss_data_t   data_in,
	input  wire signed [23:0]    height,
	output logic                 valid_s4,
	output fss_pkg::fss_result_t result_s4
);
	import fss_pkg::*;

	logic signed [63:0] c_w, s_w, u_w, sq_w, v_w, h_w;

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [63:0] s_s1, c_s1, sqc_s1, sqs_s1, us_s1, uc_s1, vh_s1;
	logic [19:0]        u_s1;
	logic signed [63:0] s_s2, c_s2, us_s2, uc_s2;
	logic [19:0]        u_s2;
	logic [19:0]        px_s2, pz_s2;
	logic [23:0]        py_s2;
	logic signed [63:0] s_s3, c_s3, us_s3, uc_s3, uus_s3, uuc_s3;
	logic [19:0]        px_s3, pz_s3;
	logic [23:0]        py_s3;
	logic [20:0]        dux_s3, duz_s3;

	logic signed [63:0] us_r, uc_r, uus_w, uuc_w, dux_w, duz_w, dux2_w, duz2_w;

	// First stage operands.
	always_comb begin
		c_w  = data_in.neg ? -64'(data_in.x) : 64'(data_in.x);
		s_w  = 64'(data_in.y);
		u_w  = $signed({44'd0, data_in.u});
		sq_w = $signed({1'b0, data_in.res[62:0]});
		v_w  = $signed({47'd0, data_in.v});
		h_w  = 64'(height);
	end

	// Second stage: round the first products, derive positions.
	always_comb begin
		us_r = rnd(us_s1, FracBits);
		uc_r = rnd(uc_s1, FracBits);
	end

	// Third stage: second products and the first-derivative sums.
	always_comb begin
		uus_w = 64'($signed({44'd0, u_s2})) * us_s2;
		uuc_w = 64'($signed({44'd0, u_s2})) * uc_s2;
		dux_w = sat(rnd(c_s2 - 2 * us_s2, AngBits + 1 - FracBits), -64'sd786432, 64'sd786432);
		duz_w = sat(rnd(s_s2 + 2 * uc_s2, AngBits + 1 - FracBits), -64'sd786432, 64'sd786432);
	end

	// Fourth stage: second-derivative sums.
	always_comb begin
		dux2_w = sat(rnd(-(c_s3 + 4 * us_s3 + 4 * rnd(uuc_s3, FracBits)),
			AngBits + 2 - FracBits), -64'sd8388608, 64'sd8388607);
		duz2_w = sat(rnd(-(s_s3 - 4 * uc_s3 + 4 * rnd(uus_s3, FracBits)),
			AngBits + 2 - FracBits), -64'sd8388608, 64'sd8388607);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1   <= s_w;
			c_s1   <= c_w;
			u_s1   <= data_in.u;
			sqc_s1 <= sq_w * c_w;
			sqs_s1 <= sq_w * s_w;
			us_s1  <= u_w * s_w;
			uc_s1  <= u_w * c_w;
			vh_s1  <= v_w * h_w;

			s_s2  <= s_s1;
			c_s2  <= c_s1;
			u_s2  <= u_s1;
			us_s2 <= us_r;
			uc_s2 <= uc_r;
			px_s2 <= 20'(sat(rnd(sqc_s1, 54 - FracBits), -64'sd262144, 64'sd262144));
			pz_s2 <= 20'(sat(rnd(sqs_s1, 54 - FracBits), -64'sd262144, 64'sd262144));
			py_s2 <= 24'(sat(rnd(vh_s1, FracBits), -64'sd8388608, 64'sd8388607));

			s_s3   <= s_s2;
			c_s3   <= c_s2;
			us_s3  <= us_s2;
			uc_s3  <= uc_s2;
			uus_s3 <= uus_w;
			uuc_s3 <= uuc_w;
			px_s3  <= px_s2;
			pz_s3  <= pz_s2;
			py_s3  <= py_s2;
			dux_s3 <= 21'(dux_w);
			duz_s3 <= 21'(duz_w);

			result_s4.pos_x    <= px_s3;
			result_s4.pos_y    <= py_s3;
			result_s4.pos_z    <= pz_s3;
			result_s4.du_x     <= dux_s3;
			result_s4.du_z     <= duz_s3;
			result_s4.dv_y     <= height;
			result_s4.normal_x <= -duz_s3;
			result_s4.normal_z <= dux_s3;
			result_s4.duu_x    <= 24'(dux2_w);
			result_s4.duu_z    <= 24'(duz2_w);
		end
	end

endmodule
`default_nettype wire

FILE: src/fermat_spiral_surface_eval_top.sv
// Top level of the Fermat spiral surface evaluator: stream ports, register port, pipeline.
`default_nettype none
// Takes one (u, v) parameter pair per clock, while s_tready is high, and returns one result
// transaction per pair: the surface point, first u- and v-derivatives, unscaled normal and
// second u-derivative. The throughput is one transaction per cycle while the output buffer
// has room. The path to the output register runs through the two angle-reduction stages,
// the 32 stages of the combined CORDIC and square-root iteration pipeline and the four
// output-arithmetic stages. A two-entry output buffer keeps the input side ready while a
// result waits. Write the height register only while no transaction is in flight.
module fermat_spiral_surface_eval_top #(
	parameter int TRIG_ITERATIONS = 20
) (
	input  wire          clk,
	input  wire          arst_n,
	// APB register port
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [2:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Input stream
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [39:0]  s_tdata,   // u_param[19:0], v_param[36:20], zero pad
	// Output stream
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [223:0] m_tdata    // pos_x, pos_y, pos_z, du_x, du_z, dv_y,
	                                // normal_x, normal_z, duu_x, duu_z, zero pad
);
	import fss_pkg::*;

	logic signed [23:0] height_q;
	logic               adv;

	// Register port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{8{height_q[23]}}, height_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 24'sd65536;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			height_q <= pwdata[23:0];
		end
	end

	// Angle reduction, first part: u scaled to Q30 modulo two pi.
	logic [34:0] t_w, ur_w;
	logic        valid_s1, valid_s2;
	logic [19:0] u_s1;
	logic [16:0] v_s1;
	logic [34:0] ur_s1;
	fss_data_t   d_s2;
	fss_data_t   fold_w;
	logic signed [35:0] r_w;

	always_comb begin
		t_w = {1'b0, s_tdata[19:0], 14'd0};
		if (t_w >= FourPiQ) begin
			ur_w = t_w - FourPiQ;
		end else if (t_w >= TwoPiQ) begin
			ur_w = t_w - TwoPiQ;
		end else begin
			ur_w = t_w;
		end
	end

	// Angle reduction, second part: into [-pi, pi], then fold into [-pi/2, pi/2].
	always_comb begin
		r_w = $signed({1'b0, ur_s1});
		if (r_w > PiQ) begin
			r_w = r_w - TwoPiS;
		end
		fold_w.neg = 1'b0;
		if (r_w > HalfPiQ) begin
			r_w = PiQ - r_w;
			fold_w.neg = 1'b1;
		end else if (r_w < -HalfPiQ) begin
			r_w = -PiQ - r_w;
			fold_w.neg = 1'b1;
		end
		fold_w.u   = u_s1;
		fold_w.v   = v_s1;
		fold_w.r   = r_w;
		fold_w.x   = GainQ;
		fold_w.y   = 35'sd0;
		fold_w.m   = {12'd0, u_s1, 32'd0};
		fold_w.res = 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1  <= s_tdata[19:0];
			v_s1  <= s_tdata[36:20];
			ur_s1 <= ur_w;
			d_s2  <= fold_w;
		end
	end

	// Iteration pipeline.
	logic      stage_valid [SqrtSteps+1];
	fss_data_t stage_data  [SqrtSteps+1];

	assign stage_valid[0] = valid_s2;
	assign stage_data[0]  = d_s2;

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
		fss_step #(
			.IDX    (k),
			.ACTIVE (k < TRIG_ITERATIONS)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (stage_valid[k]),
			.data_in  (stage_data[k]),
			.valid_s1 (stage_valid[k+1]),
			.data_s1  (stage_data[k+1])
		);
	end

	// Output arithmetic.
	logic        post_valid;
	fss_result_t post_res;

	fss_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (stage_valid[SqrtSteps]),
		.data_in   (stage_data[SqrtSteps]),
		.height    (height_q),
		.valid_s4  (post_valid),
		.result_s4 (post_res)
	);

	// Output register with a skid entry; the pipeline moves while the skid entry is free.
	logic        out_valid_q, skid_valid_q, push;
	fss_result_t out_data_q, skid_data_q;

	assign adv      = !skid_valid_q;
	assign s_tready = adv;
	assign push     = adv && post_valid;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && m_tready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && m_tready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= post_res;
			end
		end else if (!out_valid_q) begin
			if (push) begin
				out_data_q <= post_res;
			end
		end else if (push) begin
			skid_data_q <= post_res;
		end
	end

endmodule
`default_nettype wire
